[rtl/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, constants, codes and the item type passed from the hue
// classifier through the queue to the level calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HueW    = 9;
  localparam int unsigned DegW    = 6;
  localparam int unsigned PctW    = 7;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned NumChan = 3;

  localparam int unsigned ChanRed   = 0;
  localparam int unsigned ChanGreen = 1;
  localparam int unsigned ChanBlue  = 2;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [HueW-1:0] Hue60  = 9'd60;
  localparam logic [HueW-1:0] Hue120 = 9'd120;
  localparam logic [HueW-1:0] Hue180 = 9'd180;
  localparam logic [HueW-1:0] Hue240 = 9'd240;
  localparam logic [HueW-1:0] Hue300 = 9'd300;
  localparam logic [HueW-1:0] Hue360 = 9'd360;

  localparam logic [DegW-1:0] DegTop    = 6'd60;
  localparam logic [DegW-1:0] DegBottom = 6'd0;

  localparam logic [PctW-1:0] PctMax   = 7'd100;
  localparam logic [PctW-1:0] PctReset = 7'd100;

  // Level arithmetic: level = floor(v*17*k / 40000), k = d*s + 60*(100-s)
  localparam int unsigned KW    = 13;  // k <= 6000
  localparam int unsigned V17W  = 11;  // v*17 <= 1700
  localparam int unsigned XW    = 24;  // v*17*k <= 10200000
  localparam int unsigned RecipW     = 25;
  localparam int unsigned RecipShift = 40;
  localparam int unsigned ProdW      = XW + RecipW;
  // ceil(2^40 / 40000): exact floor quotient for every x below 2^24
  localparam logic [RecipW-1:0] RecipM = 25'd27487791;
  localparam logic [KW-1:0]     KStep  = 13'd60;
  localparam logic [V17W-1:0]   VScale = 11'd17;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SATURATION = 8'd0,
    REG_BRIGHTNESS = 8'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SEC_RG,
    SEC_GR,
    SEC_GB,
    SEC_BG,
    SEC_BR,
    SEC_RB,
    SEC_BAD
  } sector_e;

  // One classified request: hue offset per channel and the invalid flag
  typedef struct packed {
    logic [NumChan-1:0][DegW-1:0] deg;
    logic                         invalid;
  } item_t;

endpackage

`default_nettype wire

[rtl/hsv2rgb_front.sv]
// ----------------------------------------------------------------------------
// HSV to RGB hue classifier
// Places the hue in its 60-degree sector and gives each colour channel its
// offset, top and bottom levels being offsets of 60 and 0.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_front (
  input  wire logic [hsv2rgb_pkg::HueW-1:0] hue_i,
  output hsv2rgb_pkg::item_t                item_o
);
  import hsv2rgb_pkg::*;

  sector_e         sector;
  logic [DegW-1:0] rise;
  logic [DegW-1:0] fall;

  always_comb begin
    if (hue_i < Hue60) begin
      sector = SEC_RG;
    end else if (hue_i < Hue120) begin
      sector = SEC_GR;
    end else if (hue_i < Hue180) begin
      sector = SEC_GB;
    end else if (hue_i < Hue240) begin
      sector = SEC_BG;
    end else if (hue_i < Hue300) begin
      sector = SEC_BR;
    end else if (hue_i < Hue360) begin
      sector = SEC_RB;
    end else begin
      sector = SEC_BAD;
    end
  end

  always_comb begin
    rise = DegBottom;
    fall = DegBottom;
    item_o.deg = '0;
    item_o.invalid = 1'b0;
    case (sector)
      SEC_RG: begin
        rise = DegW'(hue_i);
        item_o.deg[ChanRed]   = DegTop;
        item_o.deg[ChanGreen] = rise;
        item_o.deg[ChanBlue]  = DegBottom;
      end
      SEC_GR: begin
        fall = DegW'(Hue120 - hue_i);
        item_o.deg[ChanRed]   = fall;
        item_o.deg[ChanGreen] = DegTop;
        item_o.deg[ChanBlue]  = DegBottom;
      end
      SEC_GB: begin
        rise = DegW'(hue_i - Hue120);
        item_o.deg[ChanRed]   = DegBottom;
        item_o.deg[ChanGreen] = DegTop;
        item_o.deg[ChanBlue]  = rise;
      end
      SEC_BG: begin
        fall = DegW'(Hue240 - hue_i);
        item_o.deg[ChanRed]   = DegBottom;
        item_o.deg[ChanGreen] = fall;
        item_o.deg[ChanBlue]  = DegTop;
      end
      SEC_BR: begin
        rise = DegW'(hue_i - Hue240);
        item_o.deg[ChanRed]   = rise;
        item_o.deg[ChanGreen] = DegBottom;
        item_o.deg[ChanBlue]  = DegTop;
      end
      SEC_RB: begin
        fall = DegW'(Hue360 - hue_i);
        item_o.deg[ChanRed]   = DegTop;
        item_o.deg[ChanGreen] = DegBottom;
        item_o.deg[ChanBlue]  = fall;
      end
      default: begin
        item_o.invalid = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/hsv2rgb_queue.sv]
// ----------------------------------------------------------------------------
// HSV to RGB request queue
// Small first-in first-out buffer of classified requests between the
// classifier and the level calculator.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_queue #(
  parameter int unsigned Depth = hsv2rgb_pkg::QueueDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire hsv2rgb_pkg::item_t push_item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output hsv2rgb_pkg::item_t      head_o,
  output logic                    empty_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/hsv2rgb_back.sv]
// ----------------------------------------------------------------------------
// HSV to RGB level calculator
// Three-stage pipeline with one lane per colour channel, ending in the
// output register that holds a result while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [hsv2rgb_pkg::PctW-1:0]  sat_i,
  input  wire logic [hsv2rgb_pkg::PctW-1:0]  bri_i,
  input  wire hsv2rgb_pkg::item_t            head_i,
  input  wire logic                          empty_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [hsv2rgb_pkg::ChanW-1:0]      red_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]      green_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]      blue_o,
  output logic                               hue_invalid_o
);
  import hsv2rgb_pkg::*;

  logic                        advance;
  logic [KW-1:0]               base_k;
  logic [V17W-1:0]             v17;

  logic                        a_valid_q, a_inv_q;
  logic [NumChan-1:0][KW-1:0]  a_k_q, a_k_d;
  logic                        b_valid_q, b_inv_q;
  logic [NumChan-1:0][XW-1:0]  b_x_q, b_x_d;
  logic [NumChan-1:0][ProdW-1:0] prod;
  logic                        out_valid_q, out_inv_q;
  logic [NumChan-1:0][ChanW-1:0] level_q, level_d;

  // Whole pipeline moves together unless the output register is held.
  assign advance = !(out_valid_q && out_stall_i);
  assign pop_o   = advance && !empty_i;

  assign base_k = KStep * KW'(PctMax - sat_i);
  assign v17    = V17W'(bri_i) * VScale;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      a_k_d[c]   = KW'(KW'(head_i.deg[c]) * KW'(sat_i)) + base_k;
      b_x_d[c]   = XW'(a_k_q[c]) * XW'(v17);
      prod[c]    = ProdW'(b_x_q[c]) * ProdW'(RecipM);
      level_d[c] = b_inv_q ? '0 : prod[c][RecipShift +: ChanW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q   <= !empty_i;
      b_valid_q   <= a_valid_q;
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_k_q     <= a_k_d;
      a_inv_q   <= head_i.invalid;
      b_x_q     <= b_x_d;
      b_inv_q   <= a_inv_q;
      level_q   <= level_d;
      out_inv_q <= b_inv_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_o         = level_q[ChanRed];
  assign green_o       = level_q[ChanGreen];
  assign blue_o        = level_q[ChanBlue];
  assign hue_invalid_o = out_inv_q;

endmodule

`default_nettype wire

[rtl/hsv_to_rgb_converter_unit.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts a stream of hue angles into 8-bit red, green and blue levels
// using saturation and brightness held in configuration registers.
// ----------------------------------------------------------------------------
// Usage:
// A request carries one hue in degrees on hue_i and is taken at a clock edge
// where in_valid_i is high and in_stall_o is low. Each request produces
// exactly one result on red_o, green_o, blue_o and hue_invalid_o, taken at an
// edge where out_valid_o is high and out_stall_i is low. A hue above 359
// yields zero levels with hue_invalid_o set.
// Saturation (register 0) and brightness (register 1), both percentages, are
// written through the cfg_valid_i / cfg_ready_o channel while no request is
// in flight; values above 100 act as 100 and other indices are ignored.
// Throughput is one request per clock cycle while out_stall_i stays low. A
// request passes through the request queue, then the two multiplier stages
// of the level lanes, the last of which feeds the output register.
// When the receiver stalls, the output register holds its result and the
// pipeline freezes; the queue still takes up to QueueDepth further requests
// before in_stall_o rises. Reset empties the queue and pipeline and sets both
// percentages to 100.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_unit #(
  parameter int unsigned QueueDepth = hsv2rgb_pkg::QueueDepthDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [hsv2rgb_pkg::HueW-1:0]    hue_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [hsv2rgb_pkg::ChanW-1:0]        red_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]        green_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]        blue_o,
  output logic                                 hue_invalid_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [hsv2rgb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [hsv2rgb_pkg::PctW-1:0]    cfg_data_i
);
  import hsv2rgb_pkg::*;

  logic [PctW-1:0] sat_q;
  logic [PctW-1:0] bri_q;
  logic [PctW-1:0] sat_clamped;
  logic [PctW-1:0] bri_clamped;

  item_t front_item;
  item_t queue_head;
  logic  queue_full;
  logic  queue_empty;
  logic  queue_pop;

  // Configuration registers: always ready, unknown indices are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= PctReset;
      bri_q <= PctReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SATURATION: sat_q <= cfg_data_i;
        REG_BRIGHTNESS: bri_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Percentages above the legal range act as 100.
  assign sat_clamped = (sat_q > PctMax) ? PctMax : sat_q;
  assign bri_clamped = (bri_q > PctMax) ? PctMax : bri_q;

  // The classifier feeds the queue directly, so a request is refused only
  // when the queue is full.
  assign in_stall_o = queue_full;

  hsv2rgb_front u_front (
    .hue_i  (hue_i),
    .item_o (front_item)
  );

  hsv2rgb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .head_o      (queue_head),
    .empty_o     (queue_empty)
  );

  hsv2rgb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sat_i         (sat_clamped),
    .bri_i         (bri_clamped),
    .head_i        (queue_head),
    .empty_i       (queue_empty),
    .pop_o         (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .hue_invalid_o (hue_invalid_o)
  );

  // An invalid hue must come out with all three levels cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hue_invalid_o |-> red_o == '0 && green_o == '0 && blue_o == '0)
    else $error("invalid hue produced non-zero levels");

  // At full brightness the leading channel of a valid hue sits at full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hue_invalid_o && bri_clamped == PctMax
      |-> red_o == '1 || green_o == '1 || blue_o == '1)
    else $error("no channel at full scale with full brightness");

  // With no saturation every valid hue gives a grey level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hue_invalid_o && sat_clamped == '0
      |-> red_o == green_o && green_o == blue_o)
    else $error("unsaturated colour is not grey");

endmodule

`default_nettype wire

[bench/hsv_to_rgb_converter_unit_test.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter unit test
// Drives hue requests into the converter under a range of saturation and
// brightness settings and checks every red, green, blue and invalid-hue
// result against a typed-in colour or an integer colour predictor kept
// inside the bench. A short table of hand-picked hues comes first, followed
// by randomised phases with random idling on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hsv_to_rgb_converter_unit_test;
  import hsv2rgb_pkg::*;

  // Drain margin used by wait_idle once every owed colour is back.
  localparam int unsigned PipeLatency  = 3;
  localparam int unsigned NumPhases    = 13;
  localparam int unsigned HuesPerPhase = 96;
  localparam int unsigned NumDirected  = 22;
  localparam int unsigned NumPlanned   = 7;
  localparam int unsigned SectorDeg    = 60;
  localparam int unsigned FullScale    = 255;
  localparam int unsigned HueCeiling   = 511;
  localparam int unsigned PctCeiling   = 127;

  // Indices outside the register map; writes to them must be ignored.
  localparam logic [CfgIdxW-1:0] IdxUnusedTop = 8'hFF;
  localparam logic [CfgIdxW-1:0] IdxUnusedLow = 8'd2;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             invalid;
  } colour_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic            typed;
    colour_t         colour;
  } hue_case_t;

  // Hand-picked hues, all issued at the reset setting of 100 % saturation and
  // 100 % brightness. Where the colour is obvious at full scale it is typed
  // in; the remaining rows go through the predictor.
  localparam hue_case_t DirectedCases [NumDirected] = '{
    '{9'd0,   1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
    '{9'd59,  1'b1, '{8'd255, 8'd250, 8'd0,   1'b0}},
    '{9'd60,  1'b1, '{8'd255, 8'd255, 8'd0,   1'b0}},
    '{9'd120, 1'b1, '{8'd0,   8'd255, 8'd0,   1'b0}},
    '{9'd180, 1'b1, '{8'd0,   8'd255, 8'd255, 1'b0}},
    '{9'd240, 1'b1, '{8'd0,   8'd0,   8'd255, 1'b0}},
    '{9'd300, 1'b1, '{8'd255, 8'd0,   8'd255, 1'b0}},
    '{9'd359, 1'b1, '{8'd255, 8'd0,   8'd4,   1'b0}},
    '{9'd360, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
    '{9'd511, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
    '{9'd1,   1'b0, '0},
    '{9'd30,  1'b0, '0},
    '{9'd90,  1'b0, '0},
    '{9'd119, 1'b0, '0},
    '{9'd150, 1'b0, '0},
    '{9'd179, 1'b0, '0},
    '{9'd210, 1'b0, '0},
    '{9'd239, 1'b0, '0},
    '{9'd256, 1'b0, '0},
    '{9'd299, 1'b0, '0},
    '{9'd330, 1'b0, '0},
    '{9'd255, 1'b0, '0}
  };

  // Settings for the first randomised phases after the reset one: both
  // extremes, values above 100 that must act as 100, and a return to reset.
  localparam logic [PctW-1:0] SatPlan [NumPlanned] = '{
    7'd0, 7'd100, 7'd127, 7'd0, 7'd101, 7'd33, 7'd100
  };
  localparam logic [PctW-1:0] BriPlan [NumPlanned] = '{
    7'd100, 7'd0, 7'd127, 7'd0, 7'd55, 7'd101, 7'd100
  };

  // Every input starts from a known value; reset is held low from time zero.
  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic [HueW-1:0]    hue_in    = '0;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [PctW-1:0]    cfg_data  = '0;

  logic               in_stall;
  logic               out_valid;
  logic [ChanW-1:0]   red;
  logic [ChanW-1:0]   green;
  logic [ChanW-1:0]   blue;
  logic               hue_invalid;
  logic               cfg_ready;

  // The bench's own copy of the two percentage registers.
  logic [PctW-1:0]    sat_pct = PctReset;
  logic [PctW-1:0]    bri_pct = PctReset;

  // Colours still owed by the converter, oldest first.
  colour_t            pending_colours [$];
  int unsigned        mismatches = 0;
  // While set, neither side inserts idle cycles.
  logic               calm = 1'b0;
  int unsigned        stall_left = 0;

  hsv_to_rgb_converter_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .hue_i         (hue_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .red_o         (red),
    .green_o       (green),
    .blue_o        (blue),
    .hue_invalid_o (hue_invalid),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Level of the ramping channel for a hue offset of deg degrees into its
  // sector. The products stay well inside 32 bits (at most 153 million).
  function automatic int unsigned ramp_level(int unsigned v, int unsigned s,
                                             int unsigned deg);
    return (v * FullScale * (deg * s + SectorDeg * (100 - s))) / 600000;
  endfunction

  // Expected colour for one hue under the current register copies. Register
  // values above 100 count as 100, and an out-of-range hue gives black with
  // the invalid flag raised.
  function automatic colour_t predict_colour(logic [HueW-1:0] hue);
    int unsigned s;
    int unsigned v;
    int unsigned h;
    int unsigned top;
    int unsigned bottom;
    int unsigned ramp;
    colour_t     c;
    s      = (sat_pct > PctMax) ? 32'(PctMax) : 32'(sat_pct);
    v      = (bri_pct > PctMax) ? 32'(PctMax) : 32'(bri_pct);
    h      = 32'(hue);
    top    = (v * FullScale) / 100;
    bottom = (v * FullScale * (100 - s)) / 10000;
    c      = '0;
    if (hue < Hue60) begin
      ramp    = ramp_level(v, s, h);
      c.red   = ChanW'(top);
      c.green = ChanW'(ramp);
      c.blue  = ChanW'(bottom);
    end else if (hue < Hue120) begin
      ramp    = ramp_level(v, s, 32'(Hue120) - h);
      c.red   = ChanW'(ramp);
      c.green = ChanW'(top);
      c.blue  = ChanW'(bottom);
    end else if (hue < Hue180) begin
      ramp    = ramp_level(v, s, h - 32'(Hue120));
      c.red   = ChanW'(bottom);
      c.green = ChanW'(top);
      c.blue  = ChanW'(ramp);
    end else if (hue < Hue240) begin
      ramp    = ramp_level(v, s, 32'(Hue240) - h);
      c.red   = ChanW'(bottom);
      c.green = ChanW'(ramp);
      c.blue  = ChanW'(top);
    end else if (hue < Hue300) begin
      ramp    = ramp_level(v, s, h - 32'(Hue240));
      c.red   = ChanW'(ramp);
      c.green = ChanW'(bottom);
      c.blue  = ChanW'(top);
    end else if (hue < Hue360) begin
      ramp    = ramp_level(v, s, 32'(Hue360) - h);
      c.red   = ChanW'(top);
      c.green = ChanW'(bottom);
      c.blue  = ChanW'(ramp);
    end else begin
      c.invalid = 1'b1;
    end
    return c;
  endfunction

  // Sends one hue request, sometimes after an idle burst. It is entered and
  // left on a falling edge; valid stays high afterwards so that back-to-back
  // requests need no dip. The expected colour is recorded at acceptance,
  // either the typed-in one or the predictor's.
  task automatic send_hue(input logic [HueW-1:0] hue, input logic typed,
                          input colour_t typed_colour);
    int unsigned gap;
    gap = (!calm && $urandom_range(5) == 0) ? $urandom_range(9, 1) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    hue_in   <= hue;
    do @(posedge clk_i); while (in_stall);
    pending_colours.push_back(typed ? typed_colour : predict_colour(hue));
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every owed colour has come back, then
  // lets the pipeline run dry for a few more cycles.
  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (pending_colours.size() == 0);
    repeat (PipeLatency + 2) @(negedge clk_i);
  endtask

  // One register write. It opens with a falling edge of its own so that
  // valid is never dropped and raised within the same time step.
  task automatic write_register(input logic [CfgIdxW-1:0] index,
                                input logic [PctW-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    if (index == REG_SATURATION) begin
      sat_pct = value;
    end else if (index == REG_BRIGHTNESS) begin
      bri_pct = value;
    end
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
               want, got);
      mismatches++;
    end
  endtask

  // Receiver back-pressure: random stall bursts, none started while the bench
  // is in a calm stretch.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(5) == 0) begin
      stall_left = $urandom_range(8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every result taken by the receiver is matched against the oldest owed
  // colour, one field at a time.
  always @(posedge clk_i) begin : result_check
    colour_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_colours.size() == 0) begin
        $display("%0t: unexpected result, actual r=%0d g=%0d b=%0d inv=%0b",
                 $time, red, green, blue, hue_invalid);
        mismatches++;
      end else begin
        want = pending_colours.pop_front();
        check_field("red", 32'(want.red), 32'(red));
        check_field("green", 32'(want.green), 32'(green));
        check_field("blue", 32'(want.blue), 32'(blue));
        check_field("hue_invalid", 32'(want.invalid), 32'(hue_invalid));
      end
    end
  end

  initial begin : stimulus
    int          edge_hue;
    int unsigned pick;
    logic [HueW-1:0] hue;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table at the reset setting.
    for (int unsigned i = 0; i < NumDirected; i++) begin
      send_hue(DirectedCases[i].hue, DirectedCases[i].typed,
               DirectedCases[i].colour);
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      // Registers only change with the converter empty.
      wait_idle();
      if (p == 0) begin
        // Writes outside the register map; the reset setting must survive.
        write_register(IdxUnusedTop, PctW'(PctCeiling));
        write_register(CfgIdxW'($urandom_range(254, 32'(IdxUnusedLow))),
                       PctW'($urandom_range(PctCeiling)));
      end else begin
        if (p <= NumPlanned) begin
          write_register(REG_SATURATION, SatPlan[p - 1]);
          write_register(REG_BRIGHTNESS, BriPlan[p - 1]);
        end else begin
          write_register(REG_SATURATION, PctW'(($urandom_range(9) == 0) ?
                         $urandom_range(PctCeiling, 101) : $urandom_range(100)));
          write_register(REG_BRIGHTNESS, PctW'(($urandom_range(9) == 0) ?
                         $urandom_range(PctCeiling, 101) : $urandom_range(100)));
        end
        if ($urandom_range(3) == 0) begin
          write_register(CfgIdxW'($urandom_range(255, 32'(IdxUnusedLow))),
                         PctW'($urandom_range(PctCeiling)));
        end
      end

      // The final phase runs with no idling at all; some others are calm too.
      calm = (p == NumPhases - 1) || ($urandom_range(4) == 0);

      for (int unsigned n = 0; n < HuesPerPhase; n++) begin
        // Now and then the sender holds off until the converter has drained.
        if (n == HuesPerPhase / 2 && p % 3 == 1) begin
          wait_idle();
        end
        // Mostly valid hues, with sector edges and out-of-range hues mixed in.
        pick = $urandom_range(19);
        if (pick < 14) begin
          hue = HueW'($urandom_range(359));
        end else if (pick < 17) begin
          edge_hue = int'($urandom_range(6)) * int'(SectorDeg)
                     + int'($urandom_range(2)) - 1;
          hue = HueW'((edge_hue < 0) ? 0 : edge_hue);
        end else begin
          hue = HueW'($urandom_range(HueCeiling, 32'(Hue360)));
        end
        send_hue(hue, 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("hsv_to_rgb_converter_unit_test: PASS");
    end else begin
      $display("hsv_to_rgb_converter_unit_test: FAIL");
    end
    $finish;
  end

  // Watchdog: many times the slowest legal run.
  initial begin
    #2_000_000;
    $display("hsv_to_rgb_converter_unit_test: FAIL");
    $finish;
  end

endmodule
